>>> design/rcdc_pkg.sv
// ----------------------------------------------------------------------------
// rcdc_pkg
// Shared types and constants of the content-defined chunker.
// ----------------------------------------------------------------------------
`default_nettype none
package rcdc_pkg;
	localparam int WINDOW_SIZE = 32;
	localparam int SLOT_W      = $clog2(WINDOW_SIZE);
	localparam int MUL_STEPS   = 9;
	localparam int STEP_W      = $clog2(MUL_STEPS + 1);
	localparam int DIV_BITS    = 4;
	localparam int DIV_ITERS   = 64 / DIV_BITS;
	localparam int DIV_CNT_W   = $clog2(DIV_ITERS);

	localparam logic [2:0] REG_MULT  = 3'd0;
	localparam logic [2:0] REG_WPOW  = 3'd1;
	localparam logic [2:0] REG_DIV   = 3'd2;
	localparam logic [2:0] REG_MIN   = 3'd3;
	localparam logic [2:0] REG_MAX   = 3'd4;

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} item_t;

	typedef struct packed {
		logic [63:0] mult;
		logic [63:0] wpow;
		logic [15:0] divisor;
		logic [15:0] min_len;
		logic [15:0] max_len;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_MOD,
		ST_FIN
	} state_t;
endpackage
`default_nettype wire

>>> design/rabin_content_defined_chunker.sv
// ----------------------------------------------------------------------------
// rabin_content_defined_chunker
// Rolling-checksum content-defined chunker with APB register port.
// ----------------------------------------------------------------------------
// The sequencer handles one byte at a time and takes the next from the queue only
// when done; each byte takes nine passes of the shared 32x32 multiplier and sixteen
// passes of the four-bit remainder unit.
// The input queue holds two bytes, so input transfers go on while a result waits.
// Reset clears the window, checksums, counters and queue; registers take
// their documented defaults.
`default_nettype none
module rabin_content_defined_chunker (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [5:0]   paddr,
	input  wire  [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	input  wire          in_valid,
	output logic         in_stall,
	input  wire  [7:0]   data_byte,
	input  wire          end_of_stream,
	output logic         out_valid,
	input  wire          out_stall,
	output logic [47:0]  chunk_start,
	output logic [15:0]  chunk_length,
	output logic [63:0]  chunk_fingerprint,
	output logic         stream_done
);
	import rcdc_pkg::*;

	cfg_t       cfg_q;
	item_t      q_item;
	logic       q_valid, q_pop;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];

	always_comb begin
		case (reg_idx)
			REG_MULT: prdata = cfg_q.mult;
			REG_WPOW: prdata = cfg_q.wpow;
			REG_DIV:  prdata = {48'd0, cfg_q.divisor};
			REG_MIN:  prdata = {48'd0, cfg_q.min_len};
			REG_MAX:  prdata = {48'd0, cfg_q.max_len};
			default:  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mult    <= 64'd3;
			cfg_q.wpow    <= 64'd1853020188851841;
			cfg_q.divisor <= 16'd4096;
			cfg_q.min_len <= 16'd1024;
			cfg_q.max_len <= 16'd8192;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_MULT: cfg_q.mult    <= pwdata;
				REG_WPOW: cfg_q.wpow    <= pwdata;
				REG_DIV:  cfg_q.divisor <= pwdata[15:0];
				REG_MIN:  cfg_q.min_len <= pwdata[15:0];
				REG_MAX:  cfg_q.max_len <= pwdata[15:0];
				default:  ;
			endcase
		end
	end

	rcdc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	rcdc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.q_valid           (q_valid),
		.q_item            (q_item),
		.q_pop             (q_pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.chunk_start       (chunk_start),
		.chunk_length      (chunk_length),
		.chunk_fingerprint (chunk_fingerprint),
		.stream_done       (stream_done)
	);
endmodule
`default_nettype wire

>>> design/rcdc_front.sv
// ----------------------------------------------------------------------------
// rcdc_front
// Input side: two-entry queue of stream bytes in front of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module rcdc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire  [7:0]          data_byte,
	input  wire                 end_of_stream,
	output logic                q_valid,
	output rcdc_pkg::item_t     q_item,
	input  wire                 q_pop
);
	import rcdc_pkg::*;

	item_t      buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= '{data: data_byte, eos: end_of_stream};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (q_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

>>> design/rcdc_mod.sv
// ----------------------------------------------------------------------------
// rcdc_mod
// Iterative remainder of a 64-bit value by a 16-bit divisor, four bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rcdc_mod (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          start,
	input  wire  [63:0]  dividend,
	input  wire  [15:0]  divisor,
	output logic         done,
	output logic [15:0]  remainder
);
	import rcdc_pkg::*;

	logic [63:0]          num_q;
	logic [16:0]          rem_q;
	logic                 busy_q;
	logic [DIV_CNT_W-1:0] iter_q;
	logic [16:0]          rem_nx;
	logic [63:0]          num_nx;

	always_comb begin
		rem_nx = rem_q;
		num_nx = num_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			rem_nx = {rem_nx[15:0], num_nx[63]};
			num_nx = {num_nx[62:0], 1'b0};
			if (rem_nx >= {1'b0, divisor}) begin
				rem_nx = rem_nx - {1'b0, divisor};
			end
		end
	end

	assign remainder = rem_q[15:0];

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_nx;
			rem_q <= rem_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iter_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == DIV_CNT_W'(DIV_ITERS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> design/rcdc_back.sv
// ----------------------------------------------------------------------------
// rcdc_back
// Sequencer: window ring, checksum and fingerprint update, cut decision,
// result register.
// ----------------------------------------------------------------------------
`default_nettype none
module rcdc_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  rcdc_pkg::cfg_t      cfg,
	input  wire                 q_valid,
	input  rcdc_pkg::item_t     q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [47:0]         chunk_start,
	output logic [15:0]         chunk_length,
	output logic [63:0]         chunk_fingerprint,
	output logic                stream_done
);
	import rcdc_pkg::*;

	state_t            state_q, state_nx;
	logic [7:0]        ring_q [WINDOW_SIZE];
	logic [SLOT_W-1:0] slot_q;
	logic [63:0]       rs_q, ch_q;
	logic [15:0]       cnt_q;
	logic [47:0]       seen_q;
	logic [7:0]        cur_q, old_q;
	logic              eos_q;
	logic [STEP_W-1:0] step_q;
	logic [63:0]       acc_q [3];
	logic [63:0]       p_s1;
	logic              pv_s1;
	logic [1:0]        pjob_s1;
	logic              phi_s1;
	logic [63:0]       op_a, op_b;
	logic [31:0]       half_a, half_b;
	logic [1:0]        job;
	logic              hi_part;
	logic [63:0]       cur_x, old_x, rs_new, ch_new;
	logic              mod_start, mod_done;
	logic [15:0]       mod_rem;
	logic              cut, emit, out_free, fin_go;

	assign cur_x = {{56{cur_q[7]}}, cur_q};
	assign old_x = {{56{old_q[7]}}, old_q};
	assign rs_new = acc_q[0] + cur_x - acc_q[2];
	assign ch_new = acc_q[1] + cur_x;

	always_comb begin
		job     = 2'd0;
		hi_part = 1'b0;
		half_a  = '0;
		half_b  = '0;
		unique case (step_q)
			STEP_W'(0): begin job = 2'd0; end
			STEP_W'(1): begin job = 2'd0; hi_part = 1'b1; end
			STEP_W'(2): begin job = 2'd0; hi_part = 1'b1; end
			STEP_W'(3): begin job = 2'd1; end
			STEP_W'(4): begin job = 2'd1; hi_part = 1'b1; end
			STEP_W'(5): begin job = 2'd1; hi_part = 1'b1; end
			STEP_W'(6): begin job = 2'd2; end
			STEP_W'(7): begin job = 2'd2; hi_part = 1'b1; end
			STEP_W'(8): begin job = 2'd2; hi_part = 1'b1; end
			default:    begin job = 2'd0; end
		endcase
		unique case (job)
			2'd0:    begin op_a = rs_q;  op_b = cfg.mult; end
			2'd1:    begin op_a = ch_q;  op_b = cfg.mult; end
			default: begin op_a = old_x; op_b = cfg.wpow; end
		endcase
		unique case (step_q)
			STEP_W'(1), STEP_W'(4), STEP_W'(7): begin
				half_a = op_a[31:0];  half_b = op_b[63:32];
			end
			STEP_W'(2), STEP_W'(5), STEP_W'(8): begin
				half_a = op_a[63:32]; half_b = op_b[31:0];
			end
			default: begin
				half_a = op_a[31:0];  half_b = op_b[31:0];
			end
		endcase
	end

	rcdc_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (rs_new),
		.divisor   (cfg.divisor),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	always_comb begin
		cut = 1'b0;
		if (cfg.divisor != 16'd0 && cnt_q >= cfg.min_len && {48'd0, mod_rem} == cfg.mult) begin
			cut = 1'b1;
		end
		if (cnt_q == cfg.max_len || cnt_q == 16'hFFFF) begin
			cut = 1'b1;
		end
		emit     = cut || eos_q;
		out_free = !out_valid || !out_stall;
		fin_go   = !emit || out_free;
	end

	always_comb begin
		state_nx  = state_q;
		q_pop     = 1'b0;
		mod_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop    = 1'b1;
					state_nx = ST_MUL;
				end
			end
			ST_MUL: begin
				if (step_q == STEP_W'(MUL_STEPS)) begin
					state_nx = ST_SUM;
				end
			end
			ST_SUM: begin
				mod_start = 1'b1;
				state_nx  = ST_MOD;
			end
			ST_MOD: begin
				if (mod_done) begin
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		p_s1    <= half_a * half_b;
		pjob_s1 <= job;
		phi_s1  <= hi_part;
		if (q_pop) begin
			cur_q <= q_item.data;
			eos_q <= q_item.eos;
			old_q <= ring_q[slot_q];
		end
		if (state_q == ST_FIN && emit && out_free) begin
			chunk_start       <= seen_q - {32'd0, cnt_q};
			chunk_length      <= cnt_q;
			chunk_fingerprint <= ch_q;
			stream_done       <= eos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ring_q    <= '{default: '0};
			slot_q    <= '0;
			rs_q      <= '0;
			ch_q      <= '0;
			cnt_q     <= '0;
			seen_q    <= '0;
			step_q    <= '0;
			pv_s1     <= 1'b0;
			acc_q     <= '{default: '0};
			out_valid <= 1'b0;
		end else begin
			state_q <= state_nx;
			pv_s1   <= (state_q == ST_MUL) && (step_q != STEP_W'(MUL_STEPS));
			if (state_q == ST_FIN && fin_go && emit) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (q_pop) begin
				ring_q[slot_q] <= q_item.data;
				slot_q <= (slot_q == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : slot_q + 1'b1;
				cnt_q  <= cnt_q + 16'd1;
				seen_q <= seen_q + 48'd1;
				step_q <= '0;
				acc_q  <= '{default: '0};
			end
			if (state_q == ST_MUL && step_q != STEP_W'(MUL_STEPS)) begin
				step_q <= step_q + 1'b1;
			end
			if (pv_s1) begin
				acc_q[pjob_s1] <= acc_q[pjob_s1] + (phi_s1 ? {p_s1[31:0], 32'd0} : p_s1);
			end
			if (state_q == ST_SUM) begin
				rs_q <= rs_new;
				ch_q <= ch_new;
			end
			if (state_q == ST_FIN && fin_go) begin
				if (eos_q) begin
					ring_q <= '{default: '0};
					slot_q <= '0;
					rs_q   <= '0;
					ch_q   <= '0;
					cnt_q  <= '0;
					seen_q <= '0;
				end else if (cut) begin
					ch_q  <= '0;
					cnt_q <= '0;
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> design/rcdc_checker.sv
// ----------------------------------------------------------------------------
// rcdc_checker
// Port-level checks of the chunker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module rcdc_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         pready,
	input wire         out_valid,
	input wire         out_stall,
	input wire [47:0]  chunk_start,
	input wire [15:0]  chunk_length,
	input wire [63:0]  chunk_fingerprint,
	input wire         stream_done
);
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> chunk_length != 16'd0)
		else $error("empty chunk");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(chunk_start) && $stable(chunk_length)
			&& $stable(chunk_fingerprint) && $stable(stream_done))
		else $error("stalled result changed");
endmodule

bind rabin_content_defined_chunker rcdc_checker u_rcdc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.pready            (pready),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.chunk_start       (chunk_start),
	.chunk_length      (chunk_length),
	.chunk_fingerprint (chunk_fingerprint),
	.stream_done       (stream_done)
);
`default_nettype wire
